/* rtl/topological_sort_kahn_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the topological sort block
// Shared property wrappers used by the checker module.
// ---------------------------------------------------------------------------
`ifndef TOPOLOGICAL_SORT_KAHN_DEFINES_SVH
`define TOPOLOGICAL_SORT_KAHN_DEFINES_SVH

// Clocked assertion with an active-low reset that disables the check.
`define TSK_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define TSK_ASSERT(lbl, prop, msg) \
    `TSK_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

/* rtl/tsort_pkg.sv */
// ---------------------------------------------------------------------------
// Topological sort package
// Sizes, derived widths and the sequencer state type.
// ---------------------------------------------------------------------------
package tsort_pkg;

    localparam int MAX_NODES = 32;
    localparam int MAX_EDGES = 256;

    localparam int NODE_W  = 5;                        // vertex number field
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);    // vertex count, queue length
    localparam int EADDR_W = $clog2(MAX_EDGES);
    localparam int ECNT_W  = $clog2(MAX_EDGES + 1);    // edge count
    localparam int DEG_W   = ECNT_W;                   // in-degree counter
    localparam int EDGE_W  = 2 * NODE_W;               // stored {to, from}

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_CNT_RD,
        ST_CNT_DEG,
        ST_CNT_WR,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_HEAD_RD,
        ST_HEAD_LD,
        ST_WALK_RD,
        ST_WALK_DEG,
        ST_WALK_WR,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

endpackage

/* rtl/tsort_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module tsort_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/topological_sort_kahn.sv */
// Loading: one edge word per cycle, s_tready stays high until a tlast word is taken.
// Sort after the tlast word: clear every in-degree RAM entry, count in-degrees over the
// stored edges, scan vertices for sources, then walk all stored edges per queued vertex;
// each RAM has a single read port.
// Output: each result word is held until m_tready; the next graph loads right after.
// Reset (aresetn low, synchronous) empties the graph and sets node_count to 32.
// ---------------------------------------------------------------------------
// Topological sort (Kahn) top level
// Edge store, in-degree RAM and order queue driven by one sequencer.
// ---------------------------------------------------------------------------
module topological_sort_kahn
    import tsort_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [NCNT_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [4:0] from_node, [9:5] to_node
    input  logic                 s_tuser,   // has_edge
    input  logic                 s_tlast,   // final_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [4:0] node
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] node_valid, [1] is_dag, [2] overflow
    output logic                 m_tlast    // last_result
);

    state_t state_reg, state_next;

    logic [NCNT_W-1:0] node_count_reg;
    logic [ECNT_W-1:0] ecount_reg, ecount_next;
    logic [ECNT_W-1:0] e_reg, e_next;
    logic [NCNT_W-1:0] i_reg, i_next;
    logic [NCNT_W-1:0] head_reg, head_next;
    logic [NCNT_W-1:0] len_reg, len_next;
    logic              dropped_reg, dropped_next;
    logic [NODE_W-1:0] cur_reg, cur_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              nvalid_reg, nvalid_next;
    logic              dag_reg, dag_next;
    logic              ovf_reg, ovf_next;
    logic              last_reg, last_next;

    logic [NCNT_W-1:0] n;
    logic [NODE_W-1:0] in_from, in_to;

    // Edge store
    logic               edge_we;
    logic [EDGE_W-1:0]  edge_rdata;
    logic [NODE_W-1:0]  e_src, e_dst;

    // In-degree RAM
    logic               deg_we;
    logic [NODE_W-1:0]  deg_waddr, deg_raddr;
    logic [DEG_W-1:0]   deg_wdata, deg_rdata;

    // Order queue
    logic               q_we;
    logic [NODE_W-1:0]  q_raddr, q_wdata, q_rdata;

    assign in_from = s_tdata[NODE_W-1:0];
    assign in_to   = s_tdata[2*NODE_W-1:NODE_W];
    assign e_src   = edge_rdata[NODE_W-1:0];
    assign e_dst   = edge_rdata[EDGE_W-1:NODE_W];

    // Vertex count in force: zero counts as one, large values saturate.
    always_comb begin
        if (node_count_reg == '0) begin
            n = NCNT_W'(1);
        end else if (node_count_reg > NCNT_W'(MAX_NODES)) begin
            n = NCNT_W'(MAX_NODES);
        end else begin
            n = node_count_reg;
        end
    end

    tsort_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk  (aclk),
        .we    (edge_we),
        .waddr (ecount_reg[EADDR_W-1:0]),
        .wdata ({in_to, in_from}),
        .raddr (e_reg[EADDR_W-1:0]),
        .rdata (edge_rdata)
    );

    tsort_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
        .aclk  (aclk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    tsort_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (len_reg[NODE_W-1:0]),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    // The edge RAM address holds still while an edge is examined, so its read
    // data stays valid across the read-modify-write of the target's in-degree.
    assign deg_raddr = (state_reg == ST_SRC_RD || state_reg == ST_SRC_CHK)
                       ? i_reg[NODE_W-1:0] : e_dst;
    assign deg_waddr = (state_reg == ST_CLEAR) ? i_reg[NODE_W-1:0] : e_dst;
    assign q_raddr   = (state_reg == ST_OUT_RD) ? i_reg[NODE_W-1:0] : head_reg[NODE_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            node_count_reg <= NCNT_W'(MAX_NODES);
            ecount_reg     <= '0;
            e_reg          <= '0;
            i_reg          <= '0;
            head_reg       <= '0;
            len_reg        <= '0;
            dropped_reg    <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ecount_reg   <= ecount_next;
            e_reg        <= e_next;
            i_reg        <= i_next;
            head_reg     <= head_next;
            len_reg      <= len_next;
            dropped_reg  <= dropped_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        node_reg   <= node_next;
        nvalid_reg <= nvalid_next;
        dag_reg    <= dag_next;
        ovf_reg    <= ovf_next;
        last_reg   <= last_next;
    end

    always_comb begin
        state_next    = state_reg;
        ecount_next   = ecount_reg;
        e_next        = e_reg;
        i_next        = i_reg;
        head_next     = head_reg;
        len_next      = len_reg;
        dropped_next  = dropped_reg;
        cur_next      = cur_reg;
        m_tvalid_next = m_tvalid_reg;
        node_next     = node_reg;
        nvalid_next   = nvalid_reg;
        dag_next      = dag_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;
        s_tready      = 1'b0;
        edge_we       = 1'b0;
        deg_we        = 1'b0;
        deg_wdata     = '0;
        q_we          = 1'b0;
        q_wdata       = e_dst;

        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser) begin
                        if ({1'b0, in_from} >= n || {1'b0, in_to} >= n ||
                            ecount_reg >= ECNT_W'(MAX_EDGES)) begin
                            dropped_next = 1'b1;
                        end else begin
                            edge_we     = 1'b1;
                            ecount_next = ecount_reg + 1'b1;
                        end
                    end
                    if (s_tlast) begin
                        i_next     = '0;
                        state_next = ST_CLEAR;
                    end
                end
            end

            ST_CLEAR: begin
                deg_we = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == NCNT_W'(MAX_NODES - 1)) begin
                    e_next     = '0;
                    state_next = ST_CNT_RD;
                end
            end

            ST_CNT_RD: begin
                if (e_reg < ecount_reg) begin
                    state_next = ST_CNT_DEG;
                end else begin
                    i_next     = '0;
                    state_next = ST_SRC_RD;
                end
            end

            ST_CNT_DEG: begin
                // Edges that reach past a lowered vertex count are ignored here.
                if ({1'b0, e_src} >= n || {1'b0, e_dst} >= n) begin
                    dropped_next = 1'b1;
                    e_next       = e_reg + 1'b1;
                    state_next   = ST_CNT_RD;
                end else begin
                    state_next = ST_CNT_WR;
                end
            end

            ST_CNT_WR: begin
                deg_we     = 1'b1;
                deg_wdata  = deg_rdata + 1'b1;
                e_next     = e_reg + 1'b1;
                state_next = ST_CNT_RD;
            end

            ST_SRC_RD: begin
                if (i_reg < n) begin
                    state_next = ST_SRC_CHK;
                end else begin
                    head_next  = '0;
                    state_next = ST_HEAD_RD;
                end
            end

            ST_SRC_CHK: begin
                if (deg_rdata == '0) begin
                    q_we     = 1'b1;
                    q_wdata  = i_reg[NODE_W-1:0];
                    len_next = len_reg + 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = ST_SRC_RD;
            end

            ST_HEAD_RD: begin
                if (head_reg < len_reg) begin
                    state_next = ST_HEAD_LD;
                end else begin
                    i_next     = '0;
                    state_next = ST_OUT_RD;
                end
            end

            ST_HEAD_LD: begin
                cur_next   = q_rdata;
                e_next     = '0;
                state_next = ST_WALK_RD;
            end

            ST_WALK_RD: begin
                if (e_reg < ecount_reg) begin
                    state_next = ST_WALK_DEG;
                end else begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_HEAD_RD;
                end
            end

            ST_WALK_DEG: begin
                if (e_src == cur_reg && {1'b0, e_dst} < n) begin
                    state_next = ST_WALK_WR;
                end else begin
                    e_next     = e_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
            end

            ST_WALK_WR: begin
                if (deg_rdata != '0) begin
                    deg_we    = 1'b1;
                    deg_wdata = deg_rdata - 1'b1;
                    if (deg_rdata == DEG_W'(1) && len_reg < NCNT_W'(MAX_NODES)) begin
                        q_we     = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                e_next     = e_reg + 1'b1;
                state_next = ST_WALK_RD;
            end

            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end

            ST_OUT_LD: begin
                nvalid_next   = i_reg < len_reg;
                node_next     = (i_reg < len_reg) ? q_rdata : '0;
                dag_next      = len_reg == n;
                ovf_next      = dropped_reg;
                last_next     = (i_reg + 1'b1) == n;
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT_WAIT;
            end

            ST_OUT_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (last_reg) begin
                        ecount_next  = '0;
                        len_next     = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(node_reg);
    assign m_tuser  = {ovf_reg, dag_reg, nvalid_reg};
    assign m_tlast  = last_reg;

endmodule

/* rtl/tsort_checker.sv */
// ---------------------------------------------------------------------------
// Topological sort port checker
// Watches the stream ports of the top level over time.
// ---------------------------------------------------------------------------
`include "topological_sort_kahn_defines.svh"

module tsort_checker
    import tsort_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    `TSK_ASSERT(a_no_load_during_output, m_tvalid |-> !s_tready, "input ready while results pending")
    `TSK_ASSERT(a_stop_after_last_in, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "input still ready after final word")
    `TSK_ASSERT(a_reopen_after_last_out, (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid), "block not reopened after last result")
    `TSK_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result word changed")

endmodule

bind topological_sort_kahn tsort_checker u_tsort_checker (.*);
